/* rtl/core/u8v_pkg.sv */
// Shared types, constants and a helper function for the UTF-8 string validator.
package u8v_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] CpMax  = 21'h10FFFF;
	localparam logic [CpWidth-1:0] SurrLo = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrHi = 21'h00DFFF;

	typedef logic [CpWidth-1:0] code_point_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_string;
	} in_item_t;

	// Smallest code point that a sequence with the given number of
	// continuation bytes may legally encode.
	function automatic code_point_t least_value(input logic [1:0] extra);
		code_point_t v;
		case (extra)
			2'd1:    v = 21'h000080;
			2'd2:    v = 21'h000800;
			2'd3:    v = 21'h010000;
			default: v = 21'h000000;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/u8v_byte_if.sv */
// Input channel of the validator: one string byte and/or end marker per item.
interface u8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_string;

	modport source(output valid, output data_byte, output has_byte,
		output end_of_string, input ready);
	modport sink(input valid, input data_byte, input has_byte,
		input end_of_string, output ready);
endinterface

/* rtl/core/u8v_verdict_if.sv */
// Output channel of the validator: one verdict per string.
interface u8v_verdict_if;
	logic valid;
	logic ready;
	logic text_valid;

	modport source(output valid, output text_valid, input ready);
	modport sink(input valid, input text_valid, output ready);
endinterface

/* rtl/core/utf8_string_validator.sv */
// Top level of the UTF-8 string validator: input register, decode step, verdict register.
// An end-marker item is held in the input register, then its verdict is registered in the verdict register.
// Throughput: one item per cycle; bytes keep flowing while a verdict waits, and input
// stalls only while an end marker sits in the input register behind an untaken verdict.
// Reset: arst_n clears the sequence state, the error flag and both valid flags at once.
module utf8_string_validator (
	input  logic          clk,
	input  logic          arst_n,
	u8v_byte_if.sink      bytes,
	u8v_verdict_if.source verdict
);

	u8v_pkg::in_item_t    item_s1;
	logic                 valid_s1;
	logic                 advance;

	logic [1:0]           bytes_left_q;
	logic [1:0]           seq_extra_q;
	u8v_pkg::code_point_t code_point_q;
	logic                 bad_seen_q;

	logic [1:0]           bytes_left_d;
	logic [1:0]           seq_extra_d;
	u8v_pkg::code_point_t code_point_d;
	logic                 bad_d;
	u8v_pkg::code_point_t cp_shift;
	logic [7:0]           b;

	logic                 out_valid_q;
	logic                 text_valid_q;

	assign advance     = valid_s1 && (!item_s1.end_of_string || !out_valid_q || verdict.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			item_s1 <= '{data_byte: bytes.data_byte, has_byte: bytes.has_byte,
				end_of_string: bytes.end_of_string};
		end
	end

	assign b        = item_s1.data_byte;
	assign cp_shift = {code_point_q[u8v_pkg::CpWidth-7:0], b[5:0]};

	// Next sequence state for a byte, before the end marker is applied.
	always_comb begin
		bytes_left_d = bytes_left_q;
		seq_extra_d  = seq_extra_q;
		code_point_d = code_point_q;
		bad_d        = bad_seen_q;
		if (item_s1.has_byte && !bad_seen_q) begin
			if (bytes_left_q == 2'd0) begin
				if (b == 8'h00) begin
					bad_d = 1'b1;
				end else if (b[7] == 1'b0) begin
					bad_d = 1'b0;
				end else if ((b & 8'hE0) == 8'hC0) begin
					seq_extra_d  = 2'd1;
					bytes_left_d = 2'd1;
					code_point_d = {16'd0, b[4:0]};
				end else if ((b & 8'hF0) == 8'hE0) begin
					seq_extra_d  = 2'd2;
					bytes_left_d = 2'd2;
					code_point_d = {17'd0, b[3:0]};
				end else if ((b & 8'hF8) == 8'hF0) begin
					seq_extra_d  = 2'd3;
					bytes_left_d = 2'd3;
					code_point_d = {18'd0, b[2:0]};
				end else begin
					bad_d = 1'b1;
				end
			end else if ((b & 8'hC0) != 8'h80) begin
				bad_d = 1'b1;
			end else begin
				code_point_d = cp_shift;
				bytes_left_d = bytes_left_q - 2'd1;
				// Range, overlong and surrogate checks once the last byte is in.
				if (bytes_left_q == 2'd1) begin
					if (cp_shift < u8v_pkg::least_value(seq_extra_q) ||
						cp_shift > u8v_pkg::CpMax ||
						(cp_shift >= u8v_pkg::SurrLo && cp_shift <= u8v_pkg::SurrHi)) begin
						bad_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			seq_extra_q  <= 2'd0;
			code_point_q <= '0;
			bad_seen_q   <= 1'b0;
		end else if (advance) begin
			if (item_s1.end_of_string) begin
				bytes_left_q <= 2'd0;
				seq_extra_q  <= 2'd0;
				code_point_q <= '0;
				bad_seen_q   <= 1'b0;
			end else begin
				bytes_left_q <= bytes_left_d;
				seq_extra_q  <= seq_extra_d;
				code_point_q <= code_point_d;
				bad_seen_q   <= bad_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_string) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_string) begin
			text_valid_q <= !bad_d && (bytes_left_d == 2'd0);
		end
	end

	assign verdict.valid      = out_valid_q;
	assign verdict.text_valid = text_valid_q;

endmodule

/* rtl/core/u8v_checker.sv */
// Port-level assertions for the UTF-8 string validator and their bind.
module u8v_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_end,
	input logic out_valid,
	input logic out_ready,
	input logic out_text_valid
);

	logic in_end_acc;
	assign in_end_acc = in_valid && in_ready && in_end;

	// A pending verdict stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_text_valid))
		else $error("verdict changed while stalled");

	// With the verdict register empty, input is never back-pressured.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no verdict pending");

	// A fresh verdict rises only after an accepted end marker has passed through the input register.
	a_verdict_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_end_acc, 2))
		else $error("verdict without a matching end marker");

endmodule

bind utf8_string_validator u8v_checker u_u8v_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (bytes.valid),
	.in_ready       (bytes.ready),
	.in_end         (bytes.end_of_string),
	.out_valid      (verdict.valid),
	.out_ready      (verdict.ready),
	.out_text_valid (verdict.text_valid)
);
